// ----- design/pltc_pkg.sv -----
// Shared types and constants for the pedestrian traffic light controller.
package pltc_pkg;

    localparam int CFG_W     = 16;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;

    typedef logic [CFG_W-1:0] cfg_word_t;

    typedef enum logic [2:0] {
        PH_RED        = 3'd0,
        PH_RED_YELLOW = 3'd1,
        PH_GREEN_WAIT = 3'd2,
        PH_GREEN_WALK = 3'd3,
        PH_YELLOW     = 3'd4
    } phase_t;

    localparam logic [REG_IDX_W-1:0] REG_RED_MS           = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RED_YELLOW_MS    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_YELLOW_MS        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WALK_MS          = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RED_BEEP_ON      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RED_BEEP_PERIOD  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GRN_BEEP_ON      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_GRN_BEEP_PERIOD  = 3'd7;

    localparam cfg_word_t CFG_RESET [REG_COUNT] = '{
        16'd10000, 16'd2000, 16'd2000, 16'd5000,
        16'd250,   16'd500,  16'd500,  16'd2000
    };

endpackage

// ----- design/pedestrian_traffic_light_controller_core.sv -----
// Pedestrian traffic light controller: phase sequencer, buzzer pattern and register port.
// Each result word is registered and shows in the cycle after its tick is accepted.
// Throughput: one tick per cycle while results are taken; the register frees when taken.
// The phase and buzzer counters advance in the same cycle that a tick is accepted.
// Reset (rst_n low, asynchronous): phase red, both counters zero, registers at defaults,
// result register empty.
module pedestrian_traffic_light_controller_core
    import pltc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // tick stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] red_lamp, [1] yellow_lamp, [2] green_lamp,
                                   // [3] buzzer_on, [6:4] phase_now, [7] zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_word_t        cfg_reg [REG_COUNT];
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CFG_W-1:0] phase_elapsed_reg;
    logic [CFG_W-1:0] phase_elapsed_next;
    logic [CFG_W-1:0] beep_elapsed_reg;
    logic [CFG_W-1:0] beep_elapsed_next;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic [7:0]       m_tdata_next;

    logic             s_accept;
    logic             cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic             button;
    logic [CFG_W:0]   pe_inc;
    logic [CFG_W:0]   be_inc;
    logic [CFG_W-1:0] be_red_next;
    logic [CFG_W-1:0] be_grn_next;
    logic             buz_red;
    logic             buz_grn;
    logic             r_lamp;
    logic             y_lamp;
    logic             g_lamp;
    logic             buz;
    phase_t           phase_shown;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = {16'd0, cfg_reg[cfg_idx]};

    assign s_tready = ~m_tvalid_reg | m_tready;
    assign s_accept = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign button   = s_tdata[0];

    assign pe_inc = {1'b0, phase_elapsed_reg} + 17'd1;
    assign be_inc = {1'b0, beep_elapsed_reg} + 17'd1;

    assign be_red_next = (be_inc >= {1'b0, cfg_reg[REG_RED_BEEP_PERIOD]}) ? '0 : be_inc[CFG_W-1:0];
    assign be_grn_next = (be_inc >= {1'b0, cfg_reg[REG_GRN_BEEP_PERIOD]}) ? '0 : be_inc[CFG_W-1:0];
    assign buz_red     = beep_elapsed_reg < cfg_reg[REG_RED_BEEP_ON];
    assign buz_grn     = beep_elapsed_reg < cfg_reg[REG_GRN_BEEP_ON];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_write)
        begin
            cfg_reg[cfg_idx] <= pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_RED;
            phase_elapsed_reg <= '0;
            beep_elapsed_reg  <= '0;
        end
        else if (s_accept)
        begin
            phase_reg         <= phase_next;
            phase_elapsed_reg <= phase_elapsed_next;
            beep_elapsed_reg  <= beep_elapsed_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        phase_elapsed_next = pe_inc[CFG_W-1:0];
        beep_elapsed_next  = beep_elapsed_reg;
        r_lamp             = 1'b0;
        y_lamp             = 1'b0;
        g_lamp             = 1'b0;
        buz                = 1'b0;
        phase_shown        = phase_reg;
        unique case (phase_reg)
            PH_RED_YELLOW:
            begin
                r_lamp = 1'b1;
                y_lamp = 1'b1;
                if (pe_inc >= {1'b0, cfg_reg[REG_RED_YELLOW_MS]})
                begin
                    phase_next         = PH_GREEN_WAIT;
                    phase_elapsed_next = '0;
                    beep_elapsed_next  = '0;
                end
            end
            PH_GREEN_WAIT:
            begin
                g_lamp             = 1'b1;
                buz                = buz_grn;
                beep_elapsed_next  = be_grn_next;
                phase_elapsed_next = '0;
                if (button)
                begin
                    phase_next = PH_GREEN_WALK;
                end
            end
            PH_GREEN_WALK:
            begin
                g_lamp            = 1'b1;
                buz               = buz_grn;
                beep_elapsed_next = be_grn_next;
                if (pe_inc >= {1'b0, cfg_reg[REG_WALK_MS]})
                begin
                    phase_next         = PH_YELLOW;
                    phase_elapsed_next = '0;
                end
            end
            PH_YELLOW:
            begin
                y_lamp = 1'b1;
                if (pe_inc >= {1'b0, cfg_reg[REG_YELLOW_MS]})
                begin
                    phase_next         = PH_RED;
                    phase_elapsed_next = '0;
                    beep_elapsed_next  = '0;
                end
            end
            default:
            begin
                phase_shown       = PH_RED;
                phase_next        = PH_RED;
                r_lamp            = 1'b1;
                buz               = buz_red;
                beep_elapsed_next = be_red_next;
                if (pe_inc >= {1'b0, cfg_reg[REG_RED_MS]})
                begin
                    phase_next         = PH_RED_YELLOW;
                    phase_elapsed_next = '0;
                end
            end
        endcase
        m_tdata_next = {1'b0, phase_shown, buz, g_lamp, y_lamp, r_lamp};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef SYNTHESIS
    a_wait_to_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && phase_reg == PH_GREEN_WAIT && s_tdata[0] |=> phase_reg == PH_GREEN_WALK)
        else $error("button in green wait did not start walk");

    a_wait_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_GREEN_WAIT |-> phase_elapsed_reg == '0)
        else $error("phase counter running in green wait");

    a_green_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |->
            m_tdata[6:4] == PH_GREEN_WAIT || m_tdata[6:4] == PH_GREEN_WALK)
        else $error("green lamp outside green phases");

    a_quiet_yellow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[6:4] == PH_YELLOW || m_tdata[6:4] == PH_RED_YELLOW)
            |-> !m_tdata[3])
        else $error("buzzer sounding in a yellow phase");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_tvalid)
        else $error("accepted tick produced no result");
`endif

endmodule
